FILE: design/lcpf_pkg.sv
// shared constants, types and helpers of the pair force pipeline
// no dependencies; the top level, lcpf_isqrt and lcpf_div take names from here by scope
`default_nettype none
package lcpf_pkg;

	// coulomb constant 332.0636 in Q16.16
	localparam logic [24:0] KC_Q16 = 25'd21762120;

	// divider geometry: numerator, denominator, quotient widths
	localparam int NUM_W = 122;
	localparam int DEN_W = 80;
	localparam int QUO_W = 57;
	localparam logic [QUO_W-1:0] S_CAP = {1'b1, {(QUO_W-1){1'b0}}};

	// square root stages, one result bit each
	localparam int SQRT_STAGES = 32;

	// register stages from accept to the last pipeline stage
	localparam int LAT = 135;

	typedef struct packed {
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic signed [23:0] dz;
		logic               skip;
	} side_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] nlo;
		logic [DEN_W-1:0] den;
		logic             ovf;
	} div_st_t;

	typedef struct packed {
		logic [31:0] val;
		logic        clip;
	} sat_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               skipped;
		logic               saturated;
	} out_t;

	// clip a magnitude with sign to a 32 bit two's complement word
	function automatic sat_t sat_force(input logic [55:0] m, input logic neg);
		sat_t r;
		r.clip = 1'b0;
		if (neg) begin
			if (m > 56'h0000_0080_0000_00) begin
				r.val  = 32'h8000_0000;
				r.clip = 1'b1;
			end else begin
				r.val = 32'd0 - m[31:0];
			end
		end else begin
			if (m > 56'h0000_007F_FFFF_FF) begin
				r.val  = 32'h7FFF_FFFF;
				r.clip = 1'b1;
			end else begin
				r.val = m[31:0];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/lcpf_pair_if.sv
// input channel: one atom pair per item
// no dependencies
`default_nettype none
interface lcpf_pair_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] delta_x;
	logic signed [23:0] delta_y;
	logic signed [23:0] delta_z;
	logic signed [16:0] charge_first;
	logic signed [16:0] charge_second;
	logic        [15:0] sigma_first;
	logic        [15:0] sigma_second;
	logic        [15:0] well_first;
	logic        [15:0] well_second;
	logic               excluded;

	modport source (
		output valid, delta_x, delta_y, delta_z, charge_first, charge_second,
		       sigma_first, sigma_second, well_first, well_second, excluded,
		input  ready
	);
	modport sink (
		input  valid, delta_x, delta_y, delta_z, charge_first, charge_second,
		       sigma_first, sigma_second, well_first, well_second, excluded,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/lcpf_force_if.sv
// output channel: force on the first atom per item
// no dependencies
`default_nettype none
interface lcpf_force_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic               skipped;
	logic               saturated;

	modport source (
		output valid, force_x, force_y, force_z, skipped, saturated,
		input  ready
	);
	modport sink (
		input  valid, force_x, force_y, force_z, skipped, saturated,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/lj_coulomb_pair_force.sv
// top level of the lennard-jones plus coulomb pair force pipeline
// uses lcpf_pkg, lcpf_pair_if, lcpf_force_if, lcpf_isqrt and lcpf_div
`default_nettype none
// Takes one atom pair per clock cycle while ready is high and returns the
// nonbonded force on the first atom, one result per pair, in order. The
// longest chain is the lennard-jones path: two 59-stage dividers
// (sigma^2/r^2 and the final scale by 1/r^2), each producing one quotient
// bit per stage, plus the multiplier stages for the sixth power. The Coulomb
// path (a 32-stage square root, a split multiply and a 59-stage divider) runs
// alongside and is delayed to meet it. Inputs are taken every cycle while
// ready is high; ready drops only when a finished result waits at the output
// and a second one sits in the skid register behind it, and ready is driven
// from a register so it has no combinational path from the output side.
// Excluded pairs and pairs at zero distance get zero force and skipped set.
module lj_coulomb_pair_force (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lcpf_pair_if.sink    pair,
	lcpf_force_if.source result
);

	localparam int LAT = lcpf_pkg::LAT;

	// flow control: whole pipeline moves while the skid register is free
	logic           adv;
	logic [LAT-1:0] v_q;
	logic           skid_full_q;
	logic           out_v_q;
	logic           exit_v;
	lcpf_pkg::out_t out_q;
	lcpf_pkg::out_t skid_q;
	lcpf_pkg::out_t fin;

	assign adv        = ~skid_full_q;
	assign pair.ready = adv;
	assign exit_v     = v_q[LAT-1] & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], pair.valid};
		end
	end

	// stage 1: squares, charge product, sigma sum squared, epsilon product
	logic signed [47:0] px, py, pz;
	logic signed [33:0] pq;
	logic        [16:0] sig_sum;
	logic [46:0]        sqx_s1, sqy_s1, sqz_s1;
	logic signed [33:0] qq_s1;
	logic [33:0]        ssq_s1;
	logic [31:0]        eaeb_s1;
	lcpf_pkg::side_t    side_s1;

	assign px      = pair.delta_x * pair.delta_x;
	assign py      = pair.delta_y * pair.delta_y;
	assign pz      = pair.delta_z * pair.delta_z;
	assign pq      = pair.charge_first * pair.charge_second;
	assign sig_sum = {1'b0, pair.sigma_first} + {1'b0, pair.sigma_second};

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1       <= px[46:0];
			sqy_s1       <= py[46:0];
			sqz_s1       <= pz[46:0];
			qq_s1        <= pq;
			ssq_s1       <= sig_sum * sig_sum;
			eaeb_s1      <= pair.well_first * pair.well_second;
			side_s1.dx   <= pair.delta_x;
			side_s1.dy   <= pair.delta_y;
			side_s1.dz   <= pair.delta_z;
			side_s1.skip <= pair.excluded;
		end
	end

	// stage 2: squared distance, charge magnitude, skip decision
	logic [47:0]     r2_s2;
	logic [32:0]     aqq_s2;
	logic            qneg_s2;
	logic [33:0]     ssq_s2;
	logic [31:0]     eaeb_s2;
	lcpf_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s2   <= {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
			aqq_s2  <= qq_s1[33] ? 33'(-qq_s1) : qq_s1[32:0];
			qneg_s2 <= qq_s1[33];
			ssq_s2  <= ssq_s1;
			eaeb_s2 <= eaeb_s1;
			side_s2.dx   <= side_s1.dx;
			side_s2.dy   <= side_s1.dy;
			side_s2.dz   <= side_s1.dz;
			side_s2.skip <= side_s1.skip |
				(sqx_s1 == '0 && sqy_s1 == '0 && sqz_s1 == '0);
		end
	end

	// stage 3: coulomb numerator and deep overlap test
	logic [57:0] kq_s3;
	logic        deep_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			kq_s3   <= lcpf_pkg::KC_Q16 * aqq_s2;
			deep_s3 <= {18'd0, ssq_s2} >= {r2_s2, 4'd0};
		end
	end

	// square roots: r in Q8.24 and epsilon, both ready at stage 34
	logic [31:0] rq;
	logic [31:0] eps_root;

	lcpf_isqrt u_sqrt_r (
		.clk  (clk),
		.en   (adv),
		.rad  ({r2_s2, 16'd0}),
		.root (rq)
	);

	lcpf_isqrt u_sqrt_e (
		.clk  (clk),
		.en   (adv),
		.rad  ({32'd0, eaeb_s2}),
		.root (eps_root)
	);

	// sigma^2/r^2 in Q.32, ready at stage 61
	logic [lcpf_pkg::QUO_W-1:0] xq;

	lcpf_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num ({50'd0, ssq_s2, 38'd0}),
		.den ({32'd0, r2_s2}),
		.quo (xq)
	);

	// delay lines that carry operands to the stage that needs them
	logic [47:0]     r2_d_q    [70];
	logic [57:0]     kq_d_q    [33];
	logic [20:0]     c_d_q     [34];
	logic            ez_d_q    [96];
	logic            deep_d_q  [128];
	logic            qneg_d_q  [129];
	logic            pos_d_q   [65];
	logic [56:0]     magc_d_q  [36];
	lcpf_pkg::side_t side_d_q  [130];

	logic [20:0] c_s35;
	logic        ez_s35;
	logic        pos_s66;
	logic [56:0] magc;

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_d_q[0]   <= r2_s2;
			kq_d_q[0]   <= kq_s3;
			c_d_q[0]    <= c_s35;
			ez_d_q[0]   <= ez_s35;
			deep_d_q[0] <= deep_s3;
			qneg_d_q[0] <= qneg_s2;
			pos_d_q[0]  <= pos_s66;
			magc_d_q[0] <= magc;
			side_d_q[0] <= side_s2;
			for (int i = 1; i < 70; i++) r2_d_q[i] <= r2_d_q[i-1];
			for (int i = 1; i < 33; i++) kq_d_q[i] <= kq_d_q[i-1];
			for (int i = 1; i < 34; i++) c_d_q[i] <= c_d_q[i-1];
			for (int i = 1; i < 96; i++) ez_d_q[i] <= ez_d_q[i-1];
			for (int i = 1; i < 128; i++) deep_d_q[i] <= deep_d_q[i-1];
			for (int i = 1; i < 129; i++) qneg_d_q[i] <= qneg_d_q[i-1];
			for (int i = 1; i < 65; i++) pos_d_q[i] <= pos_d_q[i-1];
			for (int i = 1; i < 36; i++) magc_d_q[i] <= magc_d_q[i-1];
			for (int i = 1; i < 130; i++) side_d_q[i] <= side_d_q[i-1];
		end
	end

	// stages 35-36: coulomb divisor r2*r, split in two partial products
	logic [55:0] dpl_s35, dph_s35;
	logic [79:0] dd_s36;

	always_ff @(posedge clk) begin
		if (adv) begin
			dpl_s35 <= r2_d_q[31][23:0] * rq;
			dph_s35 <= r2_d_q[31][47:24] * rq;
			c_s35   <= 21'(eps_root[15:0]) * 21'd24;
			ez_s35  <= eps_root == '0;
			dd_s36  <= {24'd0, dpl_s35} + {dph_s35, 24'd0};
		end
	end

	// coulomb magnitude in Q.24, ready at stage 95
	lcpf_div u_div_c (
		.clk (clk),
		.en  (adv),
		.num ({30'd0, kq_d_q[32], 34'd0}),
		.den (dd_s36),
		.quo (magc)
	);

	// stages 62-66: x^2 and x^3 (sr6), then the sign and size of 2*sr6-1
	logic [41:0] x_s62, x_s63;
	logic [62:0] pa_s62, pb_s62;
	logic [83:0] xx;
	logic [51:0] x2_s63;
	logic [67:0] qa_s64, qb_s64;
	logic [93:0] x3;
	logic [61:0] sr6_s65, sr6_s66;
	logic [62:0] two;
	logic [62:0] dm_s66;

	assign xx  = {21'd0, pa_s62} + {pb_s62, 21'd0};
	assign x3  = {26'd0, qa_s64} + {qb_s64, 26'd0};
	assign two = {sr6_s65, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s62   <= xq[41:0];
			pa_s62  <= xq[41:0] * xq[20:0];
			pb_s62  <= xq[41:0] * xq[41:21];
			x_s63   <= x_s62;
			x2_s63  <= xx[83:32];
			qa_s64  <= x2_s63[25:0] * x_s63;
			qb_s64  <= x2_s63[51:26] * x_s63;
			sr6_s65 <= x3[93:32];
			sr6_s66 <= sr6_s65;
			pos_s66 <= two >= 63'h1_0000_0000;
			dm_s66  <= (two >= 63'h1_0000_0000) ? two - 63'h1_0000_0000 :
				63'h1_0000_0000 - two;
		end
	end

	// stages 67-69: t = sr6*|2*sr6-1| in Q.32 from four partial products
	logic [62:0]  ll_s67, hl_s67;
	logic [61:0]  lh_s67, hh_s67;
	logic [93:0]  pa_s68, pb_s68;
	logic [124:0] tt;
	logic [92:0]  t_s69;

	assign tt = {31'd0, pa_s68} + {pb_s68, 31'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s67 <= sr6_s66[30:0] * dm_s66[31:0];
			lh_s67 <= sr6_s66[30:0] * dm_s66[62:32];
			hl_s67 <= sr6_s66[61:31] * dm_s66[31:0];
			hh_s67 <= sr6_s66[61:31] * dm_s66[62:32];
			pa_s68 <= {31'd0, ll_s67} + {lh_s67, 32'd0};
			pb_s68 <= {31'd0, hl_s67} + {hh_s67, 32'd0};
			t_s69  <= tt[124:32];
		end
	end

	// stages 70-72: lennard-jones numerator t*24*eps
	logic [51:0]  t0_s70, t1_s70, t2_s70, t2_s71;
	logic [82:0]  u_s71;
	logic [113:0] num_s72;

	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s70  <= t_s69[30:0] * c_d_q[33];
			t1_s70  <= t_s69[61:31] * c_d_q[33];
			t2_s70  <= t_s69[92:62] * c_d_q[33];
			u_s71   <= {31'd0, t0_s70} + {t1_s70, 31'd0};
			t2_s71  <= t2_s70;
			num_s72 <= {31'd0, u_s71} + {t2_s71, 62'd0};
		end
	end

	// lennard-jones magnitude in Q.24, ready at stage 131
	logic [56:0] maglj;

	lcpf_div u_div_lj (
		.clk (clk),
		.en  (adv),
		.num ({num_s72, 8'd0}),
		.den ({32'd0, r2_d_q[69]}),
		.quo (maglj)
	);

	// stage 132: signed sum of both terms, clamped to the cap
	logic signed [58:0] sc, slj, ssum;
	logic signed [57:0] s_s132;

	always_comb begin
		sc = qneg_d_q[128] ? 59'sd0 - $signed({2'b00, magc_d_q[35]}) :
			$signed({2'b00, magc_d_q[35]});
		if (ez_d_q[95]) begin
			slj = '0;
		end else if (deep_d_q[127]) begin
			slj = $signed({2'b00, lcpf_pkg::S_CAP});
		end else if (pos_d_q[64]) begin
			slj = $signed({2'b00, maglj});
		end else begin
			slj = 59'sd0 - $signed({2'b00, maglj});
		end
		ssum = sc + slj;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ssum > $signed({2'b00, lcpf_pkg::S_CAP})) begin
				s_s132 <= $signed({1'b0, lcpf_pkg::S_CAP});
			end else if (ssum < 59'sd0 - $signed({2'b00, lcpf_pkg::S_CAP})) begin
				s_s132 <= 58'sd0 - $signed({1'b0, lcpf_pkg::S_CAP});
			end else begin
				s_s132 <= ssum[57:0];
			end
		end
	end

	// stage 133: magnitudes and signs of scale and distances
	logic [56:0] as_s133;
	logic        sneg_s133;
	logic [23:0] adx_s133, ady_s133, adz_s133;
	logic        nx_s133, ny_s133, nz_s133;
	logic        skip_s133;
	lcpf_pkg::side_t sd;

	assign sd = side_d_q[129];

	always_ff @(posedge clk) begin
		if (adv) begin
			sneg_s133 <= s_s132[57];
			as_s133   <= s_s132[57] ? 57'(-s_s132) : s_s132[56:0];
			adx_s133  <= sd.dx[23] ? 24'(-sd.dx) : sd.dx[23:0];
			ady_s133  <= sd.dy[23] ? 24'(-sd.dy) : sd.dy[23:0];
			adz_s133  <= sd.dz[23] ? 24'(-sd.dz) : sd.dz[23:0];
			nx_s133   <= sd.dx[23];
			ny_s133   <= sd.dy[23];
			nz_s133   <= sd.dz[23];
			skip_s133 <= sd.skip;
		end
	end

	// stages 134-135: |d|*|S| >> 24 per component, in two partial products
	logic [52:0] plx_s134, ply_s134, plz_s134;
	logic [51:0] phx_s134, phy_s134, phz_s134;
	logic        nx_s134, ny_s134, nz_s134, skip_s134;
	logic [80:0] mx, my, mz;
	logic [55:0] mx_s135, my_s135, mz_s135;
	logic        nx_s135, ny_s135, nz_s135, skip_s135;

	assign mx = {28'd0, plx_s134} + {phx_s134, 29'd0};
	assign my = {28'd0, ply_s134} + {phy_s134, 29'd0};
	assign mz = {28'd0, plz_s134} + {phz_s134, 29'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			plx_s134  <= adx_s133 * as_s133[28:0];
			phx_s134  <= adx_s133 * as_s133[56:29];
			ply_s134  <= ady_s133 * as_s133[28:0];
			phy_s134  <= ady_s133 * as_s133[56:29];
			plz_s134  <= adz_s133 * as_s133[28:0];
			phz_s134  <= adz_s133 * as_s133[56:29];
			nx_s134   <= nx_s133 ^ sneg_s133;
			ny_s134   <= ny_s133 ^ sneg_s133;
			nz_s134   <= nz_s133 ^ sneg_s133;
			skip_s134 <= skip_s133;
			mx_s135   <= mx[79:24];
			my_s135   <= my[79:24];
			mz_s135   <= mz[79:24];
			nx_s135   <= nx_s134;
			ny_s135   <= ny_s134;
			nz_s135   <= nz_s134;
			skip_s135 <= skip_s134;
		end
	end

	// final saturation, skipped pairs forced to zero
	lcpf_pkg::sat_t fx, fy, fz;

	assign fx = lcpf_pkg::sat_force(mx_s135, nx_s135);
	assign fy = lcpf_pkg::sat_force(my_s135, ny_s135);
	assign fz = lcpf_pkg::sat_force(mz_s135, nz_s135);

	always_comb begin
		if (skip_s135) begin
			fin.force_x   = '0;
			fin.force_y   = '0;
			fin.force_z   = '0;
			fin.skipped   = 1'b1;
			fin.saturated = 1'b0;
		end else begin
			fin.force_x   = $signed(fx.val);
			fin.force_y   = $signed(fy.val);
			fin.force_z   = $signed(fz.val);
			fin.skipped   = 1'b0;
			fin.saturated = fx.clip | fy.clip | fz.clip;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			if (skid_full_q) begin
				out_v_q     <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_v_q <= exit_v;
			end
		end else if (exit_v) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			out_q <= skid_full_q ? skid_q : fin;
		end else if (exit_v) begin
			skid_q <= fin;
		end
	end

	assign result.valid     = out_v_q;
	assign result.force_x   = out_q.force_x;
	assign result.force_y   = out_q.force_y;
	assign result.force_z   = out_q.force_z;
	assign result.skipped   = out_q.skipped;
	assign result.saturated = out_q.saturated;

endmodule
`default_nettype wire

FILE: design/lcpf_isqrt.sv
// pipelined integer square root of a 64 bit value, one root bit per stage
// uses lcpf_pkg for the stage count
`default_nettype none
module lcpf_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] rad,
	output logic      [31:0] root
);

	logic [63:0] v_q [lcpf_pkg::SQRT_STAGES];
	logic [63:0] r_q [lcpf_pkg::SQRT_STAGES];

	for (genvar i = 0; i < lcpf_pkg::SQRT_STAGES; i++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] vin;
		logic [63:0] rin;
		logic [63:0] trial;
		logic        ge;

		if (i == 0) begin : g_first
			assign vin = rad;
			assign rin = '0;
		end else begin : g_next
			assign vin = v_q[i-1];
			assign rin = r_q[i-1];
		end

		assign trial = rin + BIT;
		assign ge    = vin >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				v_q[i] <= ge ? vin - trial : vin;
				r_q[i] <= ge ? (rin >> 1) + BIT : rin >> 1;
			end
		end
	end

	assign root = r_q[lcpf_pkg::SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

FILE: design/lcpf_div.sv
// pipelined restoring divider, one quotient bit per stage, result capped
// uses lcpf_pkg for widths, the cap and the stage record type
`default_nettype none
module lcpf_div (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [lcpf_pkg::NUM_W-1:0]   num,
	input  wire logic [lcpf_pkg::DEN_W-1:0]   den,
	output logic      [lcpf_pkg::QUO_W-1:0]   quo
);

	localparam int QW = lcpf_pkg::QUO_W;
	localparam int DW = lcpf_pkg::DEN_W;
	localparam int NW = lcpf_pkg::NUM_W;

	lcpf_pkg::div_st_t st_q [QW+1];
	logic [QW-1:0]     quo_q;
	logic              ovf;

	// quotient of 2^QW or more, or a zero divisor, ends in the cap
	assign ovf = {{(DW+QW-NW){1'b0}}, num} >= {den, {QW{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0].ovf <= ovf;
			st_q[0].rem <= ovf ? '0 : {{(DW-NW+QW){1'b0}}, num[NW-1:QW]};
			st_q[0].nlo <= num[QW-1:0];
			st_q[0].quo <= '0;
			st_q[0].den <= den;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [DW:0]   shifted;
		logic [DW+1:0] diff;
		logic          ge;

		assign shifted = {st_q[j-1].rem, st_q[j-1].nlo[QW-1]};
		assign diff    = {1'b0, shifted} - {2'b00, st_q[j-1].den};
		assign ge      = ~diff[DW+1];

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[j].rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				st_q[j].quo <= {st_q[j-1].quo[QW-2:0], ge};
				st_q[j].nlo <= {st_q[j-1].nlo[QW-2:0], 1'b0};
				st_q[j].den <= st_q[j-1].den;
				st_q[j].ovf <= st_q[j-1].ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= (st_q[QW].ovf || st_q[QW].quo > lcpf_pkg::S_CAP) ?
				lcpf_pkg::S_CAP : st_q[QW].quo;
		end
	end

	assign quo = quo_q;

endmodule
`default_nettype wire
